// File: sv/sda_pkg.sv
// Shared types and constants for the stable descending argsort unit.
// Holds the request/result payload structs and the sort sequencer control struct.
// No dependencies.
package sda_pkg;

  localparam int unsigned MAX_KEYS_DEF = 1024;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned INDEX_W      = 10;
  localparam int unsigned STATUS_W     = 2;

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DROPPED = 2'd2;

  typedef struct packed {
    logic                    action;
    logic signed [KEY_W-1:0] key_value;
    logic                    final_key;
  } sda_req_t;

  typedef struct packed {
    logic [INDEX_W-1:0]      sorted_index;
    logic signed [KEY_W-1:0] sorted_key;
    logic                    last_rank;
    logic [STATUS_W-1:0]     status;
  } sda_rsp_t;

  // status of the merge sequencer as seen by the top level
  typedef struct packed {
    logic busy;     // a pass is running, sequencer owns the buffers
    logic done;     // one-cycle pulse when the order is complete
    logic src_sel;  // buffer holding the current source (0 = A, 1 = B)
    logic wr_en;    // write of one merged entry into the other buffer
  } sda_sort_ctl_t;

endpackage

// File: sv/sda_ram.sv
// Generic simple RAM: one write port, two read ports with registered data.
// No dependencies.
module sda_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// File: sv/sda_merge_seq.sv
// Bottom-up merge sequencer with one shared signed key comparator.
// Ping-pongs {key, index} entries between two buffers; uses sda_pkg.
module sda_merge_seq #(
  parameter int unsigned MAX_KEYS = sda_pkg::MAX_KEYS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           start,
  input  logic [$clog2(MAX_KEYS+1)-1:0]                  count,
  input  logic [sda_pkg::KEY_W+$clog2(MAX_KEYS)-1:0]     head_l,
  input  logic [sda_pkg::KEY_W+$clog2(MAX_KEYS)-1:0]     head_r,
  output logic [$clog2(MAX_KEYS)-1:0]                    rd_addr_l,
  output logic [$clog2(MAX_KEYS)-1:0]                    rd_addr_r,
  output logic [$clog2(MAX_KEYS)-1:0]                    wr_addr,
  output logic [sda_pkg::KEY_W+$clog2(MAX_KEYS)-1:0]     wr_data,
  output sda_pkg::sda_sort_ctl_t                         ctl
);

  localparam int unsigned IDX_W = $clog2(MAX_KEYS);
  localparam int unsigned CNT_W = $clog2(MAX_KEYS+1);
  localparam int unsigned SW    = CNT_W + 2;
  localparam int unsigned ENT_W = sda_pkg::KEY_W + IDX_W;

  typedef enum logic [2:0] {
    M_IDLE  = 3'b001,
    M_SETUP = 3'b010,
    M_MERGE = 3'b100
  } mstate_t;

  mstate_t       state, state_next;
  logic [SW-1:0] n, n_next;
  logic [SW-1:0] w, w_next;
  logic [SW-1:0] base, base_next;
  logic [SW-1:0] pl, pl_next;
  logic [SW-1:0] pr, pr_next;
  logic [SW-1:0] mid, mid_next;
  logic [SW-1:0] hi, hi_next;
  logic [SW-1:0] po, po_next;
  logic          src, src_next;
  logic          done, done_next;

  logic [SW-1:0] w_dbl, base_w, base_2w, mid_c, hi_c, po_inc;
  logic          l_ok, r_ok, take_r, wr_en;

  assign w_dbl   = w << 1;
  assign base_w  = base + w;
  assign base_2w = base + w_dbl;
  assign mid_c   = (base_w < n) ? base_w : n;
  assign hi_c    = (base_2w < n) ? base_2w : n;
  assign po_inc  = po + SW'(1);

  // left run wins ties, which keeps equal keys in index order
  assign l_ok   = pl < mid;
  assign r_ok   = pr < hi;
  assign take_r = !l_ok || (r_ok && ($signed(head_r[ENT_W-1 -: sda_pkg::KEY_W]) >
                                     $signed(head_l[ENT_W-1 -: sda_pkg::KEY_W])));

  always_comb begin
    state_next = state;
    n_next     = n;
    w_next     = w;
    base_next  = base;
    pl_next    = pl;
    pr_next    = pr;
    mid_next   = mid;
    hi_next    = hi;
    po_next    = po;
    src_next   = src;
    done_next  = 1'b0;
    wr_en      = 1'b0;
    unique case (state)
      M_IDLE: begin
        if (start) begin
          n_next    = SW'(count);
          w_next    = SW'(1);
          base_next = '0;
          src_next  = 1'b0;
          if (count <= CNT_W'(1)) begin
            done_next = 1'b1;
          end else begin
            state_next = M_SETUP;
          end
        end
      end
      M_SETUP: begin
        pl_next    = base;
        pr_next    = mid_c;
        mid_next   = mid_c;
        hi_next    = hi_c;
        po_next    = base;
        state_next = M_MERGE;
      end
      M_MERGE: begin
        wr_en   = 1'b1;
        po_next = po_inc;
        if (take_r) begin
          pr_next = pr + SW'(1);
        end else begin
          pl_next = pl + SW'(1);
        end
        if (po_inc == hi) begin
          state_next = M_SETUP;
          base_next  = base_2w;
          if (base_2w >= n) begin
            w_next    = w_dbl;
            base_next = '0;
            src_next  = !src;
            if (w_dbl >= n) begin
              state_next = M_IDLE;
              done_next  = 1'b1;
            end
          end
        end
      end
      default: state_next = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      src   <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      src   <= src_next;
      done  <= done_next;
    end
    n    <= n_next;
    w    <= w_next;
    base <= base_next;
    pl   <= pl_next;
    pr   <= pr_next;
    mid  <= mid_next;
    hi   <= hi_next;
    po   <= po_next;
  end

  // read ahead on the next pointers so the heads are current each cycle
  assign rd_addr_l = pl_next[IDX_W-1:0];
  assign rd_addr_r = pr_next[IDX_W-1:0];
  assign wr_addr   = po[IDX_W-1:0];
  assign wr_data   = take_r ? head_r : head_l;

  assign ctl.busy    = (state != M_IDLE);
  assign ctl.done    = done;
  assign ctl.src_sel = src;
  assign ctl.wr_en   = wr_en;

endmodule

// File: sv/stable_descending_argsort_unit.sv
// Stable descending argsort unit: top level.
// Depends on sda_pkg, sda_ram and sda_merge_seq.
//
// Load requests (action 0) write one signed 32-bit key each, one request per
// cycle while idle; keys beyond MAX_KEYS are dropped and every rank fetched
// from that set then reports status 2. The load that carries final_key closes
// the set and starts a bottom-up merge sort that orders key positions from
// largest to smallest key, equal keys staying in ascending position order. The
// sort runs on one comparator stepping through two ping-pong buffers of {key,
// position} entries: each pass writes every entry once, with one setup step
// per merged pair, and there are ceil(log2 n) passes; req_ready stays low
// meanwhile. A single key needs no pass. Fetch requests (action 1) read the
// result buffer through its registered read port, req_ready staying low until
// the result register takes the read data, and return one rank per request
// with its position, key and a last-rank marker. A fetch before the order is
// ready or after the last rank returns status 1 with zero fields. The result
// register lets the next request be taken while a result waits. A load after
// a finished set starts a new set. There is no clearing pass after reset.
module stable_descending_argsort_unit #(
  parameter int unsigned MAX_KEYS = sda_pkg::MAX_KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  sda_pkg::sda_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output sda_pkg::sda_rsp_t rsp
);

  localparam int unsigned IDX_W = $clog2(MAX_KEYS);
  localparam int unsigned CNT_W = $clog2(MAX_KEYS+1);
  localparam int unsigned ENT_W = sda_pkg::KEY_W + IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SORT  = 3'b010,
    ST_FETCH = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   key_count, key_count_next;
  logic [CNT_W-1:0]   fetch_pointer, fetch_pointer_next;
  logic               sorted_ready, sorted_ready_next;
  logic               dropped_flag, dropped_flag_next;
  logic               res_sel, res_sel_next;
  logic               rsp_valid_next;
  sda_pkg::sda_rsp_t  rsp_next;

  logic               accept, full, load_we, sort_start, empty, rsp_free;
  logic [CNT_W-1:0]   kc_base;
  logic [ENT_W-1:0]   fetch_ent;

  // buffer ports
  logic               a_we, b_we;
  logic [IDX_W-1:0]   a_waddr, a_raddr0, a_raddr1, b_raddr0, b_raddr1;
  logic [ENT_W-1:0]   a_wdata, a_q0, a_q1, b_q0, b_q1;

  // sequencer ports
  logic [IDX_W-1:0]        m_rd_l, m_rd_r, m_wr_addr;
  logic [ENT_W-1:0]        m_wr_data, head_l, head_r;
  sda_pkg::sda_sort_ctl_t  ctl;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  // a load after a finished set starts counting from zero again
  assign kc_base = sorted_ready ? '0 : key_count;
  assign full    = (kc_base == CNT_W'(MAX_KEYS));
  assign load_we = accept && (req.action == sda_pkg::ACT_LOAD) && !full;

  assign empty = !sorted_ready || (fetch_pointer >= key_count);

  always_comb begin
    state_next         = state;
    key_count_next     = key_count;
    fetch_pointer_next = fetch_pointer;
    sorted_ready_next  = sorted_ready;
    dropped_flag_next  = dropped_flag;
    res_sel_next       = res_sel;
    rsp_valid_next     = rsp_valid && !rsp_ready;
    rsp_next           = rsp;
    sort_start         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.action == sda_pkg::ACT_LOAD) begin
            if (sorted_ready) begin
              fetch_pointer_next = '0;
              sorted_ready_next  = 1'b0;
            end
            dropped_flag_next = (sorted_ready ? 1'b0 : dropped_flag) | full;
            key_count_next    = full ? kc_base : kc_base + CNT_W'(1);
            if (req.final_key) begin
              fetch_pointer_next = '0;
              sort_start         = 1'b1;
              state_next         = ST_SORT;
            end
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_SORT: begin
        if (ctl.done) begin
          sorted_ready_next = 1'b1;
          res_sel_next      = ctl.src_sel;
          state_next        = ST_IDLE;
        end
      end
      ST_FETCH: begin
        // hold the read data until the result register frees up
        if (rsp_free) begin
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
          if (empty) begin
            rsp_next.sorted_index = '0;
            rsp_next.sorted_key   = '0;
            rsp_next.last_rank    = 1'b0;
            rsp_next.status       = sda_pkg::STAT_EMPTY;
          end else begin
            rsp_next.sorted_index = sda_pkg::INDEX_W'(fetch_ent[IDX_W-1:0]);
            rsp_next.sorted_key   = fetch_ent[ENT_W-1 -: sda_pkg::KEY_W];
            rsp_next.last_rank    = (fetch_pointer + CNT_W'(1) == key_count);
            rsp_next.status       = dropped_flag ? sda_pkg::STAT_DROPPED
                                                 : sda_pkg::STAT_OK;
            fetch_pointer_next    = fetch_pointer + CNT_W'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      key_count     <= '0;
      fetch_pointer <= '0;
      sorted_ready  <= 1'b0;
      dropped_flag  <= 1'b0;
      res_sel       <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      key_count     <= key_count_next;
      fetch_pointer <= fetch_pointer_next;
      sorted_ready  <= sorted_ready_next;
      dropped_flag  <= dropped_flag_next;
      res_sel       <= res_sel_next;
      rsp_valid     <= rsp_valid_next;
    end
    rsp <= rsp_next;
  end

  // Buffer A takes loads and the merge output of passes that read B.
  // Buffer B only takes merge output. Port 0 serves fetches when idle.
  assign a_we     = load_we || (ctl.wr_en && ctl.src_sel);
  assign a_waddr  = ctl.busy ? m_wr_addr : kc_base[IDX_W-1:0];
  assign a_wdata  = ctl.busy ? m_wr_data : {req.key_value, kc_base[IDX_W-1:0]};
  assign a_raddr0 = ctl.busy ? m_rd_l : fetch_pointer[IDX_W-1:0];
  assign a_raddr1 = m_rd_r;
  assign b_we     = ctl.wr_en && !ctl.src_sel;
  assign b_raddr0 = ctl.busy ? m_rd_l : fetch_pointer[IDX_W-1:0];
  assign b_raddr1 = m_rd_r;

  assign head_l    = ctl.src_sel ? b_q0 : a_q0;
  assign head_r    = ctl.src_sel ? b_q1 : a_q1;
  assign fetch_ent = res_sel ? b_q0 : a_q0;

  sda_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_KEYS)
  ) u_buf_a (
    .clk    (clk),
    .we     (a_we),
    .waddr  (a_waddr),
    .wdata  (a_wdata),
    .raddr0 (a_raddr0),
    .raddr1 (a_raddr1),
    .rdata0 (a_q0),
    .rdata1 (a_q1)
  );

  sda_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_KEYS)
  ) u_buf_b (
    .clk    (clk),
    .we     (b_we),
    .waddr  (m_wr_addr),
    .wdata  (m_wr_data),
    .raddr0 (b_raddr0),
    .raddr1 (b_raddr1),
    .rdata0 (b_q0),
    .rdata1 (b_q1)
  );

  sda_merge_seq #(
    .MAX_KEYS (MAX_KEYS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .start     (sort_start),
    .count     (key_count_next),
    .head_l    (head_l),
    .head_r    (head_r),
    .rd_addr_l (m_rd_l),
    .rd_addr_r (m_rd_r),
    .wr_addr   (m_wr_addr),
    .wr_data   (m_wr_data),
    .ctl       (ctl)
  );

endmodule
